@@ rtl/srf_pll_phase_tracker_unit_defines.svh @@
// assertion macros shared by the phase tracker rtl
`ifndef SRF_PLL_PHASE_TRACKER_UNIT_DEFINES_SVH
`define SRF_PLL_PHASE_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SRFPLL_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define SRFPLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRFPLL_ASSERT(lbl, ante, cons, msg)
`define SRFPLL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/srfpll_pkg.sv @@
// types, constants and microprogram of the phase tracker
`timescale 1ns / 1ps
`default_nettype none

package srfpll_pkg;

    // fixed formats
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int INTEG_FRAC_BITS = 16;
    localparam int REG_BITS        = 31;
    localparam int INTEG_BITS      = 48;
    localparam int POLY_FRAC       = 30;
    localparam int MUL_BITS        = 32;
    localparam int PROD_BITS       = 2 * MUL_BITS;
    localparam int TAB_BITS        = SAMPLE_BITS - 1;
    localparam int K_BITS          = SINE_TABLE_BITS + 1;
    localparam int CFG_IDX_BITS    = 3;
    localparam int PC_BITS         = 5;

    localparam logic [K_BITS-1:0] QTR = K_BITS'(1 << SINE_TABLE_BITS);

    // odd sine polynomial, q30
    localparam logic signed [MUL_BITS-1:0] C1 = 32'sd1686629713;
    localparam logic signed [MUL_BITS-1:0] C3 = -32'sd693598669;
    localparam logic signed [MUL_BITS-1:0] C5 = 32'sd85569305;
    localparam logic signed [MUL_BITS-1:0] C7 = -32'sd5026995;
    localparam logic signed [MUL_BITS-1:0] C9 = 32'sd172272;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOMINAL_STEP = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PROP_GAIN    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTEG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_MIN     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_MAX     = 3'd4;

    // register reset values
    localparam logic [REG_BITS-1:0] RST_NOMINAL_STEP = 31'd21474836;
    localparam logic [REG_BITS-1:0] RST_PROP_GAIN    = 31'd3417826;
    localparam logic [REG_BITS-1:0] RST_INTEG_GAIN   = 31'd447981158;
    localparam logic [REG_BITS-1:0] RST_STEP_MIN     = 31'd19327352;
    localparam logic [REG_BITS-1:0] RST_STEP_MAX     = 31'd23622320;

    typedef logic [3:0]         t_alu;
    typedef logic [3:0]         t_mul;
    typedef logic [1:0]         t_coef;
    typedef logic [1:0]         t_cond;
    typedef logic [PC_BITS-1:0] t_pc;

    // datapath write-back operations
    localparam t_alu ALU_NOP   = 4'd0;
    localparam t_alu ALU_LDX   = 4'd1;
    localparam t_alu ALU_X2    = 4'd2;
    localparam t_alu ALU_POLY  = 4'd3;
    localparam t_alu ALU_S     = 4'd4;
    localparam t_alu ALU_TAB   = 4'd5;
    localparam t_alu ALU_ACC   = 4'd6;
    localparam t_alu ALU_D     = 4'd7;
    localparam t_alu ALU_Q     = 4'd8;
    localparam t_alu ALU_INT   = 4'd9;
    localparam t_alu ALU_SUM   = 4'd10;
    localparam t_alu ALU_CLAMP = 4'd11;
    localparam t_alu ALU_PHASE = 4'd12;

    // multiplier operand pairs
    localparam t_mul MUL_NONE = 4'd0;
    localparam t_mul MUL_XX   = 4'd1;
    localparam t_mul MUL_C9X2 = 4'd2;
    localparam t_mul MUL_PX2  = 4'd3;
    localparam t_mul MUL_PX   = 4'd4;
    localparam t_mul MUL_SMAX = 4'd5;
    localparam t_mul MUL_ACS  = 4'd6;
    localparam t_mul MUL_BSN  = 4'd7;
    localparam t_mul MUL_BCS  = 4'd8;
    localparam t_mul MUL_ASN  = 4'd9;
    localparam t_mul MUL_IGQ  = 4'd10;
    localparam t_mul MUL_PGQ  = 4'd11;

    // polynomial coefficient for the add step
    localparam t_coef COEF_C7 = 2'd0;
    localparam t_coef COEF_C5 = 2'd1;
    localparam t_coef COEF_C3 = 2'd2;
    localparam t_coef COEF_C1 = 2'd3;

    // sequencing
    localparam t_cond COND_NEXT     = 2'd0;
    localparam t_cond COND_WAIT_IN  = 2'd1;
    localparam t_cond COND_LOOP     = 2'd2;
    localparam t_cond COND_HOLD_OUT = 2'd3;

    // landmark steps of the program
    localparam t_pc PC_IDLE = 5'd0;
    localparam t_pc PC_LDX  = 5'd1;
    localparam t_pc PC_TAB  = 5'd15;
    localparam t_pc PC_FIN  = 5'd25;
    localparam t_pc PC_LAST = 5'd25;

    typedef struct packed {
        t_alu  alu;
        t_mul  mul;
        t_coef coef;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_alu  alu;
        t_mul  mul;
        t_coef coef;
        logic  pass;
        logic  in_ready;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } t_stat;

    function automatic t_uword uw(t_alu alu, t_mul mul, t_coef coef, t_cond cond,
                                  t_pc target);
        t_uword w;
        w.alu    = alu;
        w.mul    = mul;
        w.coef   = coef;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            5'd0:  w = uw(ALU_NOP,   MUL_NONE, COEF_C7, COND_WAIT_IN,  PC_IDLE);
            5'd1:  w = uw(ALU_LDX,   MUL_NONE, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd2:  w = uw(ALU_NOP,   MUL_XX,   COEF_C7, COND_NEXT,     PC_IDLE);
            5'd3:  w = uw(ALU_X2,    MUL_NONE, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd4:  w = uw(ALU_NOP,   MUL_C9X2, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd5:  w = uw(ALU_POLY,  MUL_NONE, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd6:  w = uw(ALU_NOP,   MUL_PX2,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd7:  w = uw(ALU_POLY,  MUL_NONE, COEF_C5, COND_NEXT,     PC_IDLE);
            5'd8:  w = uw(ALU_NOP,   MUL_PX2,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd9:  w = uw(ALU_POLY,  MUL_NONE, COEF_C3, COND_NEXT,     PC_IDLE);
            5'd10: w = uw(ALU_NOP,   MUL_PX2,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd11: w = uw(ALU_POLY,  MUL_NONE, COEF_C1, COND_NEXT,     PC_IDLE);
            5'd12: w = uw(ALU_NOP,   MUL_PX,   COEF_C7, COND_NEXT,     PC_IDLE);
            5'd13: w = uw(ALU_S,     MUL_NONE, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd14: w = uw(ALU_NOP,   MUL_SMAX, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd15: w = uw(ALU_TAB,   MUL_NONE, COEF_C7, COND_LOOP,     PC_LDX);
            5'd16: w = uw(ALU_NOP,   MUL_ACS,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd17: w = uw(ALU_ACC,   MUL_BSN,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd18: w = uw(ALU_D,     MUL_BCS,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd19: w = uw(ALU_ACC,   MUL_ASN,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd20: w = uw(ALU_Q,     MUL_NONE, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd21: w = uw(ALU_NOP,   MUL_IGQ,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd22: w = uw(ALU_INT,   MUL_PGQ,  COEF_C7, COND_NEXT,     PC_IDLE);
            5'd23: w = uw(ALU_SUM,   MUL_NONE, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd24: w = uw(ALU_CLAMP, MUL_NONE, COEF_C7, COND_NEXT,     PC_IDLE);
            5'd25: w = uw(ALU_PHASE, MUL_NONE, COEF_C7, COND_HOLD_OUT, PC_IDLE);
            default: w = uw(ALU_NOP, MUL_NONE, COEF_C7, COND_HOLD_OUT, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/srfpll_seq.sv @@
// microprogram sequencer: step counter, control store and jumps
`timescale 1ns / 1ps
`default_nettype none
`include "srf_pll_phase_tracker_unit_defines.svh"

module srfpll_seq (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire srfpll_pkg::t_stat   i_stat,
    output srfpll_pkg::t_ctrl        o_ctrl
);
    import srfpll_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    logic   r_pass;
    logic   n_pass;
    logic   w_hold;
    t_uword w_uw;

    // current control word
    assign w_uw = ucode(r_pc);

    // next step and table pass flag
    always_comb begin
        n_pc   = r_pc + t_pc'(1);
        n_pass = r_pass;
        w_hold = 1'b0;
        case (w_uw.cond)
            COND_NEXT: begin
            end
            COND_WAIT_IN: begin
                if (i_stat.in_valid) begin
                    n_pass = 1'b0;
                end else begin
                    n_pc = r_pc;
                end
            end
            COND_LOOP: begin
                if (!r_pass) begin
                    n_pc   = w_uw.target;
                    n_pass = 1'b1;
                end
            end
            COND_HOLD_OUT: begin
                if (i_stat.out_busy) begin
                    n_pc   = r_pc;
                    w_hold = 1'b1;
                end else begin
                    n_pc = w_uw.target;
                end
            end
            default: begin
                n_pc = PC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_IDLE;
            r_pass <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_pass <= n_pass;
        end
    end

    // control out, write-back suppressed while the result waits
    assign o_ctrl.alu      = w_hold ? ALU_NOP : w_uw.alu;
    assign o_ctrl.mul      = w_uw.mul;
    assign o_ctrl.coef     = w_uw.coef;
    assign o_ctrl.pass     = r_pass;
    assign o_ctrl.in_ready = (w_uw.cond == COND_WAIT_IN);

    `SRFPLL_ASSERT(a_pc_range, 1'b1, r_pc <= PC_LAST, "step counter left the program")
    `SRFPLL_ASSERT_NEXT(a_second_pass, (r_pc == PC_TAB) && !r_pass,
        (r_pc == PC_LDX) && r_pass, "table loop did not run its second pass")
    `SRFPLL_ASSERT_NEXT(a_fin_hold, (r_pc == PC_FIN) && i_stat.out_busy, r_pc == PC_FIN,
        "finish step left while the result register was full")

endmodule

`default_nettype wire

@@ rtl/srf_pll_phase_tracker_unit.sv @@
// synchronous reference frame pll: park transform, pi loop and phase accumulator
//
// channel   direction  handshake                     word
// s_axis    in         s_axis_tvalid/s_axis_tready   alpha_in, beta_in
// m_axis    out        m_axis_tvalid/m_axis_tready   phase, freq_step, d_component, q_error
// cfg       in         i_cfg_wr_en (no wait)         register index and 31-bit value
//
// each item runs from its accept to the next accept through the accept step, two
// 15-step sine evaluations and ten steps of park, pi and phase update
// all products go through one shared 32x32 multiplier with a registered result,
// and the dependent polynomial chain sets the step count
// synchronous active-low reset loads the register defaults and clears phase and integrator
// the result sits in an output register; a stalled output holds the sequencer at
// its last step only if the next result is ready before the old one is taken
`timescale 1ns / 1ps
`default_nettype none
`include "srf_pll_phase_tracker_unit_defines.svh"

module srf_pll_phase_tracker_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // cfg port
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [30:0] i_cfg_data,
    // input words
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] alpha_in, [31:16] beta_in
    // result words
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata    // [31:0] phase, [62:32] freq_step,
                                        // [78:63] d_component, [94:79] q_error, [95] zero
);
    import srfpll_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam logic signed [PROD_BITS-1:0] TAB_HALF  = PROD_BITS'(64'sd1 <<< (POLY_FRAC - 1));
    localparam logic signed [PROD_BITS-1:0] PARK_HALF =
        PROD_BITS'(64'sd1 <<< (SAMPLE_BITS - 2));
    localparam logic signed [PROD_BITS-1:0] SAMP_MAX64 =
        PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] SAMP_MIN64 = -SAMP_MAX64 - PROD_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] INTEG_HI64 =
        PROD_BITS'((64'sd1 <<< (INTEG_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] INTEG_LO64 = -INTEG_HI64 - PROD_BITS'(1);

    // saturate a wide value to a sample
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [PROD_BITS-1:0] v);
        logic signed [PROD_BITS-1:0] c;
        c = v;
        if (c > SAMP_MAX64) c = SAMP_MAX64;
        if (c < SAMP_MIN64) c = SAMP_MIN64;
        return c[SAMPLE_BITS-1:0];
    endfunction

    t_ctrl w_ctrl;
    t_stat w_stat;

    // configuration registers
    logic [REG_BITS-1:0] r_nominal_step;
    logic [REG_BITS-1:0] r_prop_gain;
    logic [REG_BITS-1:0] r_integ_gain;
    logic [REG_BITS-1:0] r_step_min;
    logic [REG_BITS-1:0] r_step_max;

    // loop state
    logic [PHASE_BITS-1:0]        r_phase;
    logic signed [INTEG_BITS-1:0] r_integ;
    logic signed [INTEG_BITS-1:0] n_integ;

    // datapath working registers
    logic signed [SAMPLE_BITS-1:0] r_alpha;
    logic signed [SAMPLE_BITS-1:0] r_beta;
    logic signed [MUL_BITS-1:0]    r_x;
    logic signed [MUL_BITS-1:0]    r_x2;
    logic signed [MUL_BITS-1:0]    r_p;
    logic signed [MUL_BITS-1:0]    r_s;
    logic [TAB_BITS-1:0]           r_t0;
    logic [TAB_BITS-1:0]           r_t1;
    logic [TAB_BITS-1:0]           n_tab;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [PROD_BITS-1:0]   r_acc;
    logic signed [SAMPLE_BITS-1:0] r_d;
    logic signed [SAMPLE_BITS-1:0] r_q;
    logic [REG_BITS-1:0]           r_step;
    logic [REG_BITS-1:0]           n_step;

    // output register
    logic                          r_o_valid;
    logic [PHASE_BITS-1:0]         r_o_phase;
    logic [REG_BITS-1:0]           r_o_step;
    logic signed [SAMPLE_BITS-1:0] r_o_d;
    logic signed [SAMPLE_BITS-1:0] r_o_q;

    logic                          w_in_acc;
    logic                          w_fin;
    logic [SINE_TABLE_BITS-1:0]    w_idx;
    logic [1:0]                    w_quad;
    logic [K_BITS-1:0]             w_k;
    logic signed [SAMPLE_BITS-1:0] w_t0s;
    logic signed [SAMPLE_BITS-1:0] w_t1s;
    logic signed [SAMPLE_BITS-1:0] w_sn;
    logic signed [SAMPLE_BITS-1:0] w_cs;
    logic signed [MUL_BITS-1:0]    w_mul_a;
    logic signed [MUL_BITS-1:0]    w_mul_b;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [PROD_BITS-1:0]   w_sh30;
    logic signed [PROD_BITS-1:0]   w_sh15;
    logic signed [PROD_BITS-1:0]   w_tab;
    logic signed [PROD_BITS-1:0]   w_integ64;
    logic signed [PROD_BITS-1:0]   w_isum;
    logic signed [PROD_BITS-1:0]   w_ssum;
    logic signed [PROD_BITS-1:0]   w_cl;
    logic signed [PROD_BITS-1:0]   w_min64;
    logic signed [PROD_BITS-1:0]   w_max64;
    logic signed [MUL_BITS-1:0]    w_coef;

    srfpll_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // handshakes
    assign s_axis_tready   = w_ctrl.in_ready;
    assign w_in_acc        = s_axis_tvalid && s_axis_tready;
    assign w_stat.in_valid = s_axis_tvalid;
    assign w_stat.out_busy = r_o_valid && !m_axis_tready;
    assign w_fin           = (w_ctrl.alu == ALU_PHASE);

    // table address from the phase
    assign w_quad = r_phase[PHASE_BITS-1 -: 2];
    assign w_idx  = r_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign w_k    = w_ctrl.pass ? (QTR - {1'b0, w_idx}) : {1'b0, w_idx};

    // quadrant mapping of the two table entries
    assign w_t0s = {1'b0, r_t0};
    assign w_t1s = {1'b0, r_t1};
    always_comb begin
        case (w_quad)
            QUAD_0: begin
                w_sn = w_t0s;
                w_cs = w_t1s;
            end
            QUAD_1: begin
                w_sn = w_t1s;
                w_cs = -w_t0s;
            end
            QUAD_2: begin
                w_sn = -w_t0s;
                w_cs = -w_t1s;
            end
            default: begin
                w_sn = -w_t1s;
                w_cs = w_t0s;
            end
        endcase
    end

    // shared multiplier operands
    always_comb begin
        case (w_ctrl.mul)
            MUL_XX: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
            end
            MUL_C9X2: begin
                w_mul_a = C9;
                w_mul_b = r_x2;
            end
            MUL_PX2: begin
                w_mul_a = r_p;
                w_mul_b = r_x2;
            end
            MUL_PX: begin
                w_mul_a = r_p;
                w_mul_b = r_x;
            end
            MUL_SMAX: begin
                w_mul_a = r_s;
                w_mul_b = SAMP_MAX64[MUL_BITS-1:0];
            end
            MUL_ACS: begin
                w_mul_a = MUL_BITS'(r_alpha);
                w_mul_b = MUL_BITS'(w_cs);
            end
            MUL_BSN: begin
                w_mul_a = MUL_BITS'(r_beta);
                w_mul_b = MUL_BITS'(w_sn);
            end
            MUL_BCS: begin
                w_mul_a = MUL_BITS'(r_beta);
                w_mul_b = MUL_BITS'(w_cs);
            end
            MUL_ASN: begin
                w_mul_a = MUL_BITS'(r_alpha);
                w_mul_b = MUL_BITS'(w_sn);
            end
            MUL_IGQ: begin
                w_mul_a = {1'b0, r_integ_gain};
                w_mul_b = MUL_BITS'(r_q);
            end
            MUL_PGQ: begin
                w_mul_a = {1'b0, r_prop_gain};
                w_mul_b = MUL_BITS'(r_q);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_sh30 = r_prod >>> POLY_FRAC;
    assign w_sh15 = r_prod >>> (SAMPLE_BITS - 1);

    // polynomial coefficient
    always_comb begin
        case (w_ctrl.coef)
            COEF_C7: w_coef = C7;
            COEF_C5: w_coef = C5;
            COEF_C3: w_coef = C3;
            default: w_coef = C1;
        endcase
    end

    // table entry: round, scale back and clamp to the positive sample range
    always_comb begin
        w_tab = (r_prod + TAB_HALF) >>> POLY_FRAC;
        if (w_tab < 64'sd0) begin
            n_tab = '0;
        end else if (w_tab > SAMP_MAX64) begin
            n_tab = SAMP_MAX64[TAB_BITS-1:0];
        end else begin
            n_tab = w_tab[TAB_BITS-1:0];
        end
    end

    // integrator update with saturation
    assign w_integ64 = PROD_BITS'(r_integ);
    always_comb begin
        w_isum = w_integ64 + w_sh15;
        if (w_isum > INTEG_HI64) w_isum = INTEG_HI64;
        if (w_isum < INTEG_LO64) w_isum = INTEG_LO64;
        n_integ = w_isum[INTEG_BITS-1:0];
    end

    // unclamped step: nominal plus proportional plus integer part of the integrator
    assign w_ssum = $signed({{(PROD_BITS-REG_BITS){1'b0}}, r_nominal_step}) + w_sh15
                  + (w_integ64 >>> INTEG_FRAC_BITS);

    // step clamp, max first so the lower limit wins when they cross
    assign w_min64 = $signed({{(PROD_BITS-REG_BITS){1'b0}}, r_step_min});
    assign w_max64 = $signed({{(PROD_BITS-REG_BITS){1'b0}}, r_step_max});
    always_comb begin
        w_cl = r_acc;
        if (w_cl > w_max64) w_cl = w_max64;
        if (w_cl < w_min64) w_cl = w_min64;
        n_step = w_cl[REG_BITS-1:0];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal_step <= RST_NOMINAL_STEP;
            r_prop_gain    <= RST_PROP_GAIN;
            r_integ_gain   <= RST_INTEG_GAIN;
            r_step_min     <= RST_STEP_MIN;
            r_step_max     <= RST_STEP_MAX;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NOMINAL_STEP: r_nominal_step <= i_cfg_data;
                CFG_PROP_GAIN:    r_prop_gain    <= i_cfg_data;
                CFG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data;
                CFG_STEP_MIN:     r_step_min     <= i_cfg_data;
                CFG_STEP_MAX:     r_step_max     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // loop state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_integ   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_ctrl.alu == ALU_INT) begin
                r_integ <= n_integ;
            end
            if (w_fin) begin
                r_phase   <= r_phase + PHASE_BITS'(r_step);
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_in_acc) begin
            r_alpha <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_beta  <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        case (w_ctrl.alu)
            ALU_LDX:   r_x    <= {1'b0, w_k, {(POLY_FRAC-SINE_TABLE_BITS){1'b0}}};
            ALU_X2:    r_x2   <= w_sh30[MUL_BITS-1:0];
            ALU_POLY:  r_p    <= w_coef + w_sh30[MUL_BITS-1:0];
            ALU_S:     r_s    <= w_sh30[MUL_BITS-1:0];
            ALU_TAB: begin
                if (w_ctrl.pass) begin
                    r_t1 <= n_tab;
                end else begin
                    r_t0 <= n_tab;
                end
            end
            ALU_ACC:   r_acc  <= r_prod;
            ALU_D:     r_d    <= sat_sample((r_acc + r_prod + PARK_HALF) >>> (SAMPLE_BITS - 1));
            ALU_Q:     r_q    <= sat_sample((r_acc - r_prod + PARK_HALF) >>> (SAMPLE_BITS - 1));
            ALU_SUM:   r_acc  <= w_ssum;
            ALU_CLAMP: r_step <= n_step;
            default: begin
            end
        endcase
        if (w_fin) begin
            r_o_phase <= r_phase + PHASE_BITS'(r_step);
            r_o_step  <= r_step;
            r_o_d     <= r_d;
            r_o_q     <= r_q;
        end
    end

    // result word
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_o_q, r_o_d, r_o_step, r_o_phase};

    `SRFPLL_ASSERT(a_step_in_range, r_o_valid && (r_step_min <= r_step_max),
        (r_o_step >= r_step_min) && (r_o_step <= r_step_max),
        "reported step outside its limits")
    `SRFPLL_ASSERT(a_valid_from_fin, $rose(r_o_valid), $past(w_ctrl.alu) == ALU_PHASE,
        "result valid rose without a finish step")
    `SRFPLL_ASSERT_NEXT(a_integ_hold, w_ctrl.alu != ALU_INT, $stable(r_integ),
        "integrator changed outside its update step")

endmodule

`default_nettype wire
